// ===== hdl/bresenham_line_rasterizer_top_assert.svh =====
// Assertion macros for the line rasterizer top level.
// Expects aclk and aresetn in the scope where the macros are used.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BLR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BLR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/blr_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies.
package blr_pkg;

    localparam int FRAME_W             = 13;
    localparam int COLOR_W             = 32;
    localparam int ADDR_W              = 24;
    localparam int COORD_BITS_DEFAULT  = 12;
    localparam int CFG_IDX_W           = 1;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd800;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd600;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // Kind of input item.
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_t;

    // Control of the pixel stage between the walker and the address stage.
    typedef struct packed {
        logic valid;
        logic last;
    } pix_ctrl_t;

endpackage

// ===== hdl/blr_walker.sv =====
// Input register and line walker: holds the Bresenham state and emits one pixel per step while a line is active.
// Depends on blr_pkg.
module blr_walker
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  req_t                         in_req,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic        [COLOR_W-1:0]    line_color_in,
    output pix_ctrl_t                    pix_ctrl,
    input  logic                         pix_ready,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic        [COLOR_W-1:0]    pix_color
);

    localparam int C = COORD_BITS;

    // Input item register.
    logic                item_valid_reg;
    req_t                item_req_reg;
    logic signed [C-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COLOR_W-1:0]  color_in_reg;

    // Line state.
    logic                line_active_reg, line_active_next;
    logic                axes_swapped_reg, axes_swapped_next;
    logic signed [C-1:0] major_pos_reg, major_pos_next;
    logic signed [C-1:0] minor_pos_reg, minor_pos_next;
    logic signed [C-1:0] major_end_reg, major_end_next;
    logic                minor_neg_reg, minor_neg_next;
    logic [C-1:0]        major_delta_reg, major_delta_next;
    logic [C-1:0]        minor_delta_reg, minor_delta_next;
    logic [C:0]          error_acc_reg, error_acc_next;
    logic [COLOR_W-1:0]  held_color_reg, held_color_next;

    // Pixel register.
    logic                pix_valid_reg, pix_valid_next;
    logic                pix_last_reg;
    logic signed [C-1:0] pix_x_reg, pix_y_reg;
    logic [COLOR_W-1:0]  pix_color_reg;

    logic emit, pix_free, item_done, is_last;

    // Setup terms for a start item.
    logic signed [C:0]   dx, dy, dmaj, dmin;
    logic [C:0]          adx, ady;
    logic                steep, flip;
    logic signed [C-1:0] a0, b0, a1, b1;
    logic [C:0]          err_sum;

    assign dx    = {x1_reg[C-1], x1_reg} - {x0_reg[C-1], x0_reg};
    assign dy    = {y1_reg[C-1], y1_reg} - {y0_reg[C-1], y0_reg};
    assign adx   = dx[C] ? (~dx + 1'b1) : dx;
    assign ady   = dy[C] ? (~dy + 1'b1) : dy;
    assign steep = ady > adx;
    assign dmaj  = steep ? dy : dx;
    assign dmin  = steep ? dx : dy;
    assign flip  = dmaj[C];
    assign a0    = steep ? y0_reg : x0_reg;
    assign b0    = steep ? x0_reg : y0_reg;
    assign a1    = steep ? y1_reg : x1_reg;
    assign b1    = steep ? x1_reg : y1_reg;

    // Handshake between the input register and the pixel register.
    assign emit      = item_valid_reg && (item_req_reg == REQ_STEP) && line_active_reg;
    assign pix_free  = !pix_valid_reg || pix_ready;
    assign item_done = item_valid_reg && (!emit || pix_free);
    assign in_ready  = !item_valid_reg || item_done;

    assign is_last = major_pos_reg >= major_end_reg;
    assign err_sum = error_acc_reg + {1'b0, minor_delta_reg};

    // Next line state.
    always_comb begin
        line_active_next  = line_active_reg;
        axes_swapped_next = axes_swapped_reg;
        major_pos_next    = major_pos_reg;
        minor_pos_next    = minor_pos_reg;
        major_end_next    = major_end_reg;
        minor_neg_next    = minor_neg_reg;
        major_delta_next  = major_delta_reg;
        minor_delta_next  = minor_delta_reg;
        error_acc_next    = error_acc_reg;
        held_color_next   = held_color_reg;
        if (item_done && (item_req_reg == REQ_START)) begin
            line_active_next  = 1'b1;
            axes_swapped_next = steep;
            major_pos_next    = flip ? a1 : a0;
            minor_pos_next    = flip ? b1 : b0;
            major_end_next    = flip ? a0 : a1;
            // Minor direction after ordering the endpoints by the major axis.
            minor_neg_next    = flip ? !dmin[C] : (dmin[C] || (dmin == '0));
            major_delta_next  = steep ? ady[C-1:0] : adx[C-1:0];
            minor_delta_next  = steep ? adx[C-1:0] : ady[C-1:0];
            error_acc_next    = '0;
            held_color_next   = color_in_reg;
        end else if (item_done && emit) begin
            if (is_last) begin
                line_active_next = 1'b0;
            end else begin
                if (err_sum >= {1'b0, major_delta_reg}) begin
                    minor_pos_next = minor_neg_reg ? (minor_pos_reg - 1'b1)
                                                   : (minor_pos_reg + 1'b1);
                    error_acc_next = err_sum - {1'b0, major_delta_reg};
                end else begin
                    error_acc_next = err_sum;
                end
                major_pos_next = major_pos_reg + 1'b1;
            end
        end
    end

    assign pix_valid_next = pix_free ? emit : pix_valid_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg    <= 1'b0;
            pix_valid_reg     <= 1'b0;
            line_active_reg   <= 1'b0;
            axes_swapped_reg  <= 1'b0;
            major_pos_reg     <= '0;
            minor_pos_reg     <= '0;
            major_end_reg     <= '0;
            minor_neg_reg     <= 1'b0;
            major_delta_reg   <= '0;
            minor_delta_reg   <= '0;
            error_acc_reg     <= '0;
            held_color_reg    <= '0;
        end else begin
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            pix_valid_reg     <= pix_valid_next;
            line_active_reg   <= line_active_next;
            axes_swapped_reg  <= axes_swapped_next;
            major_pos_reg     <= major_pos_next;
            minor_pos_reg     <= minor_pos_next;
            major_end_reg     <= major_end_next;
            minor_neg_reg     <= minor_neg_next;
            major_delta_reg   <= major_delta_next;
            minor_delta_reg   <= minor_delta_next;
            error_acc_reg     <= error_acc_next;
            held_color_reg    <= held_color_next;
        end
    end

    // Input payload is captured on every transfer.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_req_reg <= in_req;
            x0_reg       <= x_start;
            y0_reg       <= y_start;
            x1_reg       <= x_end;
            y1_reg       <= y_end;
            color_in_reg <= line_color_in;
        end
    end

    // Pixel payload, swapped back to screen axes.
    always_ff @(posedge aclk) begin
        if (pix_free && emit) begin
            pix_x_reg     <= axes_swapped_reg ? minor_pos_reg : major_pos_reg;
            pix_y_reg     <= axes_swapped_reg ? major_pos_reg : minor_pos_reg;
            pix_color_reg <= held_color_reg;
            pix_last_reg  <= is_last;
        end
    end

    assign pix_ctrl.valid = pix_valid_reg;
    assign pix_ctrl.last  = pix_last_reg;
    assign pix_x          = pix_x_reg;
    assign pix_y          = pix_y_reg;
    assign pix_color      = pix_color_reg;

endmodule

// ===== hdl/blr_addr.sv =====
// Address stage: window bounds check, frame-buffer address and the output register.
// Depends on blr_pkg.
module blr_addr
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [FRAME_W-1:0]           frame_width,
    input  logic [FRAME_W-1:0]           frame_height,
    input  pix_ctrl_t                    pix_ctrl,
    output logic                         pix_ready,
    input  logic signed [COORD_BITS-1:0] pix_x,
    input  logic signed [COORD_BITS-1:0] pix_y,
    input  logic        [COLOR_W-1:0]    pix_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic        [COLOR_W-1:0]    out_color,
    output logic        [ADDR_W-1:0]     out_addr,
    output logic                         out_visible,
    output logic                         out_last
);

    localparam int C      = COORD_BITS;
    localparam int CMP_W  = (C > FRAME_W) ? C : FRAME_W;
    localparam int PROD_W = FRAME_W + C;
    localparam int CALC_W = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    logic                out_valid_reg;
    logic signed [C-1:0] out_x_reg, out_y_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic [ADDR_W-1:0]   out_addr_reg, addr_next;
    logic                out_visible_reg, visible_next;
    logic                out_last_reg;

    logic [C-1:0]        x_u, y_u;
    logic                x_in, y_in;
    logic [PROD_W-1:0]   prod;
    logic [CALC_W-1:0]   sum;

    assign x_u = $unsigned(pix_x);
    assign y_u = $unsigned(pix_y);

    // Inside the window when not negative and below the frame size.
    assign x_in = !pix_x[C-1] && (CMP_W'(x_u) < CMP_W'(frame_width));
    assign y_in = !pix_y[C-1] && (CMP_W'(y_u) < CMP_W'(frame_height));
    assign visible_next = x_in && y_in;

    // Row stride times row plus column, wrapped to the address width.
    assign prod      = PROD_W'(frame_width) * PROD_W'(y_u);
    assign sum       = CALC_W'(prod) + CALC_W'(x_u);
    assign addr_next = visible_next ? sum[ADDR_W-1:0] : '0;

    assign pix_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pix_ready) begin
            out_valid_reg <= pix_ctrl.valid;
        end
    end

    // Result payload loads on each transfer from the pixel stage.
    always_ff @(posedge aclk) begin
        if (pix_ready && pix_ctrl.valid) begin
            out_x_reg       <= pix_x;
            out_y_reg       <= pix_y;
            out_color_reg   <= pix_color;
            out_addr_reg    <= addr_next;
            out_visible_reg <= visible_next;
            out_last_reg    <= pix_ctrl.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_color   = out_color_reg;
    assign out_addr    = out_addr_reg;
    assign out_visible = out_visible_reg;
    assign out_last    = out_last_reg;

endmodule

// ===== hdl/bresenham_line_rasterizer_top.sv =====
// Top level of the Bresenham line rasterizer: stream ports, frame registers, two stages.
// Depends on blr_pkg, blr_walker, blr_addr and bresenham_line_rasterizer_top_assert.svh.
//
// A start transfer (tuser low) loads two endpoints and a color and produces no
// output; each step transfer (tuser high) then produces one pixel until the pixel
// with tlast set, and steps while no line is active are dropped. The block takes
// one item per clock and emits one pixel per clock while the result stream does not
// stall: the whole error-term update of the walker is combinational, and the
// multiply for the address sits in its own stage behind it. The step transfer loads
// the input register; the pixel then passes the pixel register and the output
// register before it is valid on the result stream. Frame registers must be written
// through the cfg port only while no items are in flight, by the user; the block
// does not enforce this.
`include "bresenham_line_rasterizer_top_assert.svh"

module bresenham_line_rasterizer_top
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: x_start, y_start, x_end, y_end, line_color_in, zero fill.
    input  logic [((4*COORD_BITS+COLOR_W+7)/8)*8-1:0] s_tdata,
    // tuser: req_type.
    input  logic                 s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: pixel_x, pixel_y, pixel_color, pixel_address, zero fill.
    output logic [((2*COORD_BITS+COLOR_W+ADDR_W+7)/8)*8-1:0] m_tdata,
    // tuser: pixel_visible.
    output logic                 m_tuser,
    output logic                 m_tlast,
    // Register write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [FRAME_W-1:0]   cfg_wdata
);

    localparam int C        = COORD_BITS;
    localparam int M_DATA_W = ((2*COORD_BITS+COLOR_W+ADDR_W+7)/8)*8;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;

    pix_ctrl_t           pix_ctrl;
    logic                pix_ready;
    logic signed [C-1:0] pix_x, pix_y;
    logic [COLOR_W-1:0]  pix_color;

    logic signed [C-1:0] out_x, out_y;
    logic [COLOR_W-1:0]  out_color;
    logic [ADDR_W-1:0]   out_addr;
    logic                out_visible, out_last;

    // Frame size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Line state and pixel generation.
    blr_walker #(
        .COORD_BITS(COORD_BITS)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req       (req_t'(s_tuser)),
        .x_start      (s_tdata[0*C +: C]),
        .y_start      (s_tdata[1*C +: C]),
        .x_end        (s_tdata[2*C +: C]),
        .y_end        (s_tdata[3*C +: C]),
        .line_color_in(s_tdata[4*C +: COLOR_W]),
        .pix_ctrl     (pix_ctrl),
        .pix_ready    (pix_ready),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .pix_color    (pix_color)
    );

    // Bounds check, address and output register.
    blr_addr #(
        .COORD_BITS(COORD_BITS)
    ) u_addr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_width (frame_width_reg),
        .frame_height(frame_height_reg),
        .pix_ctrl    (pix_ctrl),
        .pix_ready   (pix_ready),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .pix_color   (pix_color),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_color   (out_color),
        .out_addr    (out_addr),
        .out_visible (out_visible),
        .out_last    (out_last)
    );

    // Result packing.
    assign m_tdata = M_DATA_W'({out_addr, out_color, out_y, out_x});
    assign m_tuser = out_visible;
    assign m_tlast = out_last;

    // Checks on the pipeline and the result fields.
    `BLR_ASSERT_IMPL(a_hidden_addr_zero, m_tvalid && !m_tuser, out_addr == '0, "hidden addr set")
    `BLR_ASSERT_IMPL(a_visible_not_neg, m_tvalid && m_tuser, !out_x[C-1] && !out_y[C-1], "neg pixel")
    `BLR_ASSERT_IMPL(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready, "early stall")

endmodule
